FILE: rtl/swsr_pkg.sv
`default_nettype none

package swsr_pkg;

    localparam int FRAME_BITS = 40;
    localparam int EDGE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_high_ticks;
        logic [7:0]  bit_threshold;
        logic [7:0]  timeout_ticks;
    } t_swsr_cfg;

    // last field in the lowest bits
    typedef struct packed {
        logic [7:0] check_byte;
        logic [7:0] temp_tenths;
        logic [7:0] temp_whole;
        logic [7:0] humidity_tenths;
        logic [7:0] humidity_whole;
        logic [1:0] status;
        logic       done_res;
        logic       busy_res;
        logic       drive_level;
        logic       drive_enable;
    } t_swsr_result;

    localparam int RESULT_W = $bits(t_swsr_result);

endpackage

`default_nettype wire

FILE: rtl/single_wire_sensor_receiver.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  start_request, line_level (one per tick)
// m_axis    out  m_axis_tvalid/m_axis_tready  drive, busy, done, status, five bytes
// cfg       in   i_cfg_we                     i_cfg_addr, i_cfg_wdata
//
// One transaction in gives one registered transaction out; one item per cycle unless stalled.
// The protocol state advances on each accepted input; result goes through a
// two-entry output buffer, so one more input is accepted when output stalls.
// s_axis_tready drops only when both buffer entries are full.
// Reset: idle, line assumed high, configuration back to its defaults.
`default_nettype none

module single_wire_sensor_receiver
    import swsr_pkg::*;
#(
    parameter int EDGE_LIMIT = 85
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,   // [0] start_request, [1] line_level
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] drive_enable, [1] drive_level,
                                                   // [2] busy_res, [3] done_res,
                                                   // [5:4] status, [13:6] humidity_whole,
                                                   // [21:14] humidity_tenths,
                                                   // [29:22] temp_whole,
                                                   // [37:30] temp_tenths,
                                                   // [45:38] check_byte
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_addr,
    input  wire [CFG_DATA_W-1:0]   i_cfg_wdata
);

    t_swsr_cfg    r_cfg;
    t_swsr_result core_result;
    t_swsr_result out_result;
    logic         accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_ticks    <= 16'd18000;
            r_cfg.release_high_ticks <= 8'd40;
            r_cfg.bit_threshold      <= 8'd16;
            r_cfg.timeout_ticks      <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_START_LOW:    r_cfg.start_low_ticks    <= i_cfg_wdata;
                CFG_RELEASE_HIGH: r_cfg.release_high_ticks <= i_cfg_wdata[7:0];
                CFG_BIT_THRESH:   r_cfg.bit_threshold      <= i_cfg_wdata[7:0];
                CFG_TIMEOUT:      r_cfg.timeout_ticks      <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    swsr_core #(
        .EDGE_LIMIT(EDGE_LIMIT)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (accept),
        .i_start_request(s_axis_tdata[0]),
        .i_line_level   (s_axis_tdata[1]),
        .o_result       (core_result)
    );

    swsr_skid u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (core_result),
        .o_ready(s_axis_tready),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_data (out_result)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_result};

endmodule

`default_nettype wire

FILE: rtl/swsr_core.sv
`default_nettype none

module swsr_core
    import swsr_pkg::*;
#(
    parameter int EDGE_LIMIT = 85
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_swsr_cfg    i_cfg,
    input  wire          i_accept,
    input  wire          i_start_request,
    input  wire          i_line_level,
    output t_swsr_result o_result
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LOW  = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_RECV = 2'd3;

    localparam logic [EDGE_W-1:0] EDGE_END = EDGE_W'(EDGE_LIMIT);

    logic [1:0]            r_phase,       n_phase;
    logic [15:0]           r_phase_count, n_phase_count;
    logic                  r_prev_level,  n_prev_level;
    logic [7:0]            r_run_count,   n_run_count;
    logic [EDGE_W-1:0]     r_edge_index,  n_edge_index;
    logic [5:0]            r_bits_taken,  n_bits_taken;
    logic [FRAME_BITS-1:0] r_frame_shift, n_frame_shift;

    logic        done;
    logic [39:0] bytes;
    logic [7:0]  sum;

    // bytes right-aligned: byte k holds received bits 8k..8k+7
    function automatic logic [39:0] frame_bytes(input logic [FRAME_BITS-1:0] sft,
                                                input logic [5:0] n);
        logic [39:0] res;
        logic [2:0]  full;
        logic [5:0]  sh;
        logic [7:0]  mask;
        res  = '0;
        full = n[5:3];
        mask = 8'((9'd1 << n[2:0]) - 9'd1);
        for (int k = 0; k < 5; k++) begin
            sh = n - 6'(8 * k) - 6'd8;
            if (3'(k) < full) begin
                res[8*k +: 8] = 8'(sft >> sh);
            end else if (3'(k) == full) begin
                res[8*k +: 8] = sft[7:0] & mask;
            end
        end
        return res;
    endfunction

    always_comb begin
        n_phase       = r_phase;
        n_phase_count = r_phase_count;
        n_prev_level  = r_prev_level;
        n_run_count   = r_run_count;
        n_edge_index  = r_edge_index;
        n_bits_taken  = r_bits_taken;
        n_frame_shift = r_frame_shift;
        done          = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_request) begin
                    n_frame_shift = '0;
                    n_bits_taken  = '0;
                    n_edge_index  = '0;
                    n_run_count   = '0;
                    n_phase_count = 16'd1;
                    n_phase       = PH_LOW;
                end
            end
            PH_LOW: begin
                if (r_phase_count >= i_cfg.start_low_ticks) begin
                    n_phase       = PH_HIGH;
                    n_phase_count = 16'd1;
                end else begin
                    n_phase_count = r_phase_count + 16'd1;
                end
            end
            PH_HIGH: begin
                if (r_phase_count >= 16'(i_cfg.release_high_ticks)) begin
                    n_phase       = PH_RECV;
                    n_phase_count = '0;
                    n_prev_level  = 1'b1;
                    n_run_count   = '0;
                    n_edge_index  = '0;
                    n_bits_taken  = '0;
                    n_frame_shift = '0;
                end else begin
                    n_phase_count = r_phase_count + 16'd1;
                end
            end
            PH_RECV: begin
                if (i_line_level == r_prev_level) begin
                    if (r_run_count != 8'hFF) begin
                        n_run_count = r_run_count + 8'd1;
                    end
                    if (n_run_count >= i_cfg.timeout_ticks) begin
                        done = 1'b1;
                    end
                end else begin
                    n_prev_level = i_line_level;
                    if (r_edge_index >= EDGE_W'(4) && !r_edge_index[0]
                            && r_bits_taken < 6'(FRAME_BITS)) begin
                        n_frame_shift = {r_frame_shift[FRAME_BITS-2:0],
                                         (r_run_count > i_cfg.bit_threshold)};
                        n_bits_taken  = r_bits_taken + 6'd1;
                    end
                    n_edge_index = r_edge_index + EDGE_W'(1);
                    n_run_count  = '0;
                    if (n_edge_index >= EDGE_END) begin
                        done = 1'b1;
                    end
                end
                if (done) begin
                    n_phase       = PH_IDLE;
                    n_phase_count = '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        bytes    = frame_bytes(n_frame_shift, n_bits_taken);
        sum      = bytes[7:0] + bytes[15:8] + bytes[23:16] + bytes[31:24];
        o_result = '0;
        o_result.drive_enable = (n_phase == PH_LOW) || (n_phase == PH_HIGH);
        o_result.drive_level  = (n_phase == PH_HIGH);
        o_result.busy_res     = (n_phase != PH_IDLE);
        if (done) begin
            o_result.done_res        = 1'b1;
            o_result.humidity_whole  = bytes[7:0];
            o_result.humidity_tenths = bytes[15:8];
            o_result.temp_whole      = bytes[23:16];
            o_result.temp_tenths     = bytes[31:24];
            o_result.check_byte      = bytes[39:32];
            if (n_bits_taken < 6'(FRAME_BITS)) begin
                o_result.status = ST_SHORT;
            end else if (bytes[39:32] != sum) begin
                o_result.status = ST_MISMATCH;
            end else begin
                o_result.status = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_phase_count <= '0;
            r_prev_level  <= 1'b1;
            r_run_count   <= '0;
            r_edge_index  <= '0;
            r_bits_taken  <= '0;
            r_frame_shift <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_phase_count <= n_phase_count;
            r_prev_level  <= n_prev_level;
            r_run_count   <= n_run_count;
            r_edge_index  <= n_edge_index;
            r_bits_taken  <= n_bits_taken;
            r_frame_shift <= n_frame_shift;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/swsr_skid.sv
`default_nettype none

module swsr_skid
    import swsr_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  t_swsr_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    input  wire          i_ready,
    output t_swsr_result o_data
);

    logic         r_out_valid;
    logic         r_skid_valid;
    t_swsr_result r_out_data;
    t_swsr_result r_skid_data;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/swsr_checker.sv
`default_nettype none

module swsr_checker
    import swsr_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   m_axis_tvalid,
    input wire                   m_axis_tready,
    input wire [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_swsr_result res;

    assign res = t_swsr_result'(m_axis_tdata[RESULT_W-1:0]);

    // stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.done_res |-> !res.busy_res && !res.drive_enable)
        else $error("done while still busy");

    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.done_res |-> m_axis_tdata[OUT_TDATA_W-1:4] == '0)
        else $error("status or data outside a done result");

    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.drive_enable |-> res.busy_res)
        else $error("driving the line while idle");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.status == ST_OK || res.status == ST_SHORT
                           || res.status == ST_MISMATCH))
        else $error("bad status code");

endmodule

bind single_wire_sensor_receiver swsr_checker u_swsr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

FILE: test/tb_single_wire_sensor_receiver.sv
`timescale 1ns / 100ps

module tb_single_wire_sensor_receiver;
    import swsr_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_LOW, PH_HIGH, PH_RECV} t_phase;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int STALL_LIMIT     = 1000;
    localparam int RUN_MAX         = 255;

    class swsr_tracker;
        localparam int EDGE_LIMIT = 85;

        int unsigned  low_ticks;
        int unsigned  high_ticks;
        int unsigned  threshold;
        int unsigned  timeout;
        t_phase       phase;
        int unsigned  phase_count;
        bit           prev_level;
        int unsigned  run_count;
        int unsigned  edge_index;
        int unsigned  bits_taken;
        bit [FRAME_BITS-1:0] frame;
        t_swsr_result tick_results[$];
        int           errors;

        function new();
            low_ticks   = 18000;
            high_ticks  = 40;
            threshold   = 16;
            timeout     = 255;
            phase       = PH_IDLE;
            phase_count = 0;
            prev_level  = 1'b1;
            run_count   = 0;
            edge_index  = 0;
            bits_taken  = 0;
            frame       = '0;
            errors      = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 30) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_START_LOW:    low_ticks  = value;
                CFG_RELEASE_HIGH: high_ticks = value[7:0];
                CFG_BIT_THRESH:   threshold  = value[7:0];
                CFG_TIMEOUT:      timeout    = value[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] frame_byte(int k);
            int full;
            int part;
            bit [FRAME_BITS-1:0] tmp;
            full = bits_taken / 8;
            if (k < full) begin
                tmp = frame >> (bits_taken - 8 * k - 8);
                return tmp[7:0];
            end
            if (k == full) begin
                part = bits_taken % 8;
                tmp = frame & ((40'd1 << part) - 40'd1);
                return tmp[7:0];
            end
            return 8'd0;
        endfunction

        // one sample in, one output word predicted
        function void take_sample(bit start, bit line);
            t_swsr_result r;
            bit fin;
            logic [7:0] b [5];
            logic [7:0] sum;
            r = '0;
            fin = 1'b0;
            case (phase)
                PH_IDLE: begin
                    if (start) begin
                        frame       = '0;
                        bits_taken  = 0;
                        edge_index  = 0;
                        run_count   = 0;
                        phase_count = 1;
                        phase       = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (phase_count >= low_ticks) begin
                        phase       = PH_HIGH;
                        phase_count = 1;
                    end else begin
                        phase_count = (phase_count + 1) & 16'hFFFF;
                    end
                end
                PH_HIGH: begin
                    if (phase_count >= high_ticks) begin
                        phase       = PH_RECV;
                        phase_count = 0;
                        prev_level  = 1'b1;
                        run_count   = 0;
                        edge_index  = 0;
                        bits_taken  = 0;
                        frame       = '0;
                    end else begin
                        phase_count = (phase_count + 1) & 16'hFFFF;
                    end
                end
                default: begin
                    if (line == prev_level) begin
                        if (run_count < RUN_MAX) begin
                            run_count++;
                        end
                        if (run_count >= timeout) begin
                            fin = 1'b1;
                        end
                    end else begin
                        prev_level = line;
                        if (edge_index >= 4 && edge_index % 2 == 0 && bits_taken < FRAME_BITS) begin
                            frame = {frame[FRAME_BITS-2:0], run_count > threshold};
                            bits_taken++;
                        end
                        edge_index = (edge_index + 1) & 7'h7F;
                        run_count  = 0;
                        if (edge_index >= EDGE_LIMIT) begin
                            fin = 1'b1;
                        end
                    end
                    if (fin) begin
                        for (int k = 0; k < 5; k++) begin
                            b[k] = frame_byte(k);
                        end
                        sum = b[0] + b[1] + b[2] + b[3];
                        if (bits_taken < FRAME_BITS) begin
                            r.status = ST_SHORT;
                        end else if (b[4] != sum) begin
                            r.status = ST_MISMATCH;
                        end else begin
                            r.status = ST_OK;
                        end
                        r.done_res        = 1'b1;
                        r.humidity_whole  = b[0];
                        r.humidity_tenths = b[1];
                        r.temp_whole      = b[2];
                        r.temp_tenths     = b[3];
                        r.check_byte      = b[4];
                        phase       = PH_IDLE;
                        phase_count = 0;
                    end
                end
            endcase
            r.drive_enable = (phase == PH_LOW) || (phase == PH_HIGH);
            r.drive_level  = (phase == PH_HIGH);
            r.busy_res     = (phase != PH_IDLE);
            tick_results.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) begin
                report($sformatf("%s got %0h want %0h", name, got, want));
            end
        endfunction

        function void check_output(logic [OUT_TDATA_W-1:0] data);
            t_swsr_result got;
            t_swsr_result want;
            if (tick_results.size() == 0) begin
                report("output transaction with no sample pending");
                return;
            end
            want = tick_results.pop_front();
            got  = data[RESULT_W-1:0];
            check_field("pad", 8'(data[OUT_TDATA_W-1:RESULT_W]), 8'd0);
            check_field("drive_enable", 8'(got.drive_enable), 8'(want.drive_enable));
            check_field("drive_level", 8'(got.drive_level), 8'(want.drive_level));
            check_field("busy", 8'(got.busy_res), 8'(want.busy_res));
            check_field("done", 8'(got.done_res), 8'(want.done_res));
            check_field("status", 8'(got.status), 8'(want.status));
            check_field("humidity_whole", got.humidity_whole, want.humidity_whole);
            check_field("humidity_tenths", got.humidity_tenths, want.humidity_tenths);
            check_field("temp_whole", got.temp_whole, want.temp_whole);
            check_field("temp_tenths", got.temp_tenths, want.temp_tenths);
            check_field("check_byte", got.check_byte, want.check_byte);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    swsr_tracker readings;
    bit          in_idling = 1'b1;
    bit          out_idling = 1'b1;
    bit          hold_off_req = 1'b0;
    int          quiet_cycles = 0;
    int          cfg_low = 18000;
    int          cfg_high = 40;
    int          cfg_thr = 16;
    int          cfg_tmo = 255;

    single_wire_sensor_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                readings.take_sample(s_axis_tdata[0], s_axis_tdata[1]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                readings.check_output(m_axis_tdata);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[single_wire_sensor_receiver] ERROR");
                $finish;
            end
        end
    end

    // output side: random per-transaction back-pressure, plus one long hold-off on request
    initial begin : sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = out_idling ? $urandom_range(0, 3) : 0;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic int min_of(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int at_least_one(int v);
        return (v == 0) ? 1 : v;
    endfunction

    task automatic send_tick(input bit start, input bit line);
        int gap;
        gap = in_idling ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-2){1'b0}}, line, start};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_run(input bit level, input int n, input bit busy);
        for (int i = 0; i < n; i++) begin
            send_tick(busy && ($urandom_range(0, 5) == 0), level);
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (readings.tick_results.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        readings.set_register(idx, value);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int low, input int high, input int thr, input int tmo,
                              input bit junk);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        logic [7:0]            hi [3];
        for (int i = 0; i < 3; i++) begin
            hi[i] = junk ? 8'($urandom_range(0, 255)) : 8'd0;
        end
        idx[0] = CFG_START_LOW;
        idx[1] = CFG_RELEASE_HIGH;
        idx[2] = CFG_BIT_THRESH;
        idx[3] = CFG_TIMEOUT;
        val[0] = low[15:0];
        val[1] = {hi[0], high[7:0]};
        val[2] = {hi[1], thr[7:0]};
        val[3] = {hi[2], tmo[7:0]};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx[i];
            i_cfg_wdata <= val[i];
            @(posedge i_clk);
            readings.set_register(idx[i], val[i]);
        end
        i_cfg_we <= 1'b0;
        cfg_low  = low & 16'hFFFF;
        cfg_high = high & 8'hFF;
        cfg_thr  = thr & 8'hFF;
        cfg_tmo  = tmo & 8'hFF;
    endtask

    // one wake-up plus a sensor reply: good frames, short frames, bad checksums, noise
    task automatic run_reading(input bit allow_noise);
        bit [7:0]  bytes [5];
        bit [39:0] payload;
        int        tmo;
        int        nbits;
        int        kind;
        bit        lvl;
        tmo = at_least_one(cfg_tmo);
        for (int i = 0; i < 4; i++) begin
            bytes[i] = 8'($urandom_range(0, 255));
        end
        bytes[4] = bytes[0] + bytes[1] + bytes[2] + bytes[3];
        if ($urandom_range(0, 3) == 0) begin
            bytes[4] = 8'($urandom_range(0, 255));
        end
        payload = {bytes[0], bytes[1], bytes[2], bytes[3], bytes[4]};
        nbits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 39) : 40;
        kind = allow_noise ? $urandom_range(0, 9) : 1;

        send_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (at_least_one(cfg_low) + at_least_one(cfg_high)) begin
            send_tick($urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)));
        end

        if (kind == 0) begin
            repeat ($urandom_range(20, 200)) send_tick(1'b0, 1'($urandom_range(0, 1)));
            lvl = 1'($urandom_range(0, 1));
        end else begin
            send_run(1'b1, $urandom_range(0, min_of(3, tmo - 1)), 1'b1);
            send_run(1'b0, $urandom_range(1, min_of(5, tmo)), 1'b1);
            send_run(1'b1, $urandom_range(1, min_of(5, tmo)), 1'b1);
            for (int i = 0; i < nbits; i++) begin
                send_run(1'b0, $urandom_range(1, min_of(3, tmo)), 1'b1);
                if (payload[39-i]) begin
                    send_run(1'b1, min_of(cfg_thr + 2 + $urandom_range(0, 2), tmo), 1'b1);
                end else begin
                    send_run(1'b1, $urandom_range(1, min_of(min_of(cfg_thr + 1, tmo), 8)), 1'b1);
                end
            end
            send_run(1'b0, $urandom_range(1, min_of(6, tmo)), 1'b1);
            lvl = 1'b0;
            if (nbits == 40 && kind % 3 != 0) begin
                send_run(1'b1, $urandom_range(1, min_of(6, tmo)), 1'b1);
                lvl = 1'b1;
                if (kind % 3 == 2) begin
                    // closing edge hits the edge limit
                    send_run(1'b0, 1, 1'b0);
                    lvl = 1'b0;
                end
            end
        end
        send_run(lvl, tmo + 2, 1'b0);
        repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    initial begin : stimulus
        bit [1:0] seq [15];
        int       n;
        int       thr;
        readings = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle ticks, then a short reading on the reset timing with a quick wake-up
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        wait_for_results();
        write_register(CFG_START_LOW, 16'd1);
        cfg_low    = 1;
        in_idling  = 1'b0;
        out_idling = 1'b0;
        send_tick(1'b1, 1'b0);
        repeat (at_least_one(cfg_low) + at_least_one(cfg_high)) begin
            send_tick(1'b0, 1'($urandom_range(0, 1)));
        end
        send_run(1'b1, 2, 1'b1);
        send_run(1'b0, 3, 1'b1);
        send_run(1'b1, 3, 1'b1);
        send_run(1'b0, 3, 1'b1);
        send_run(1'b1, 20, 1'b1);
        send_run(1'b0, 3, 1'b1);
        send_run(1'b1, 10, 1'b1);
        send_run(1'b0, cfg_tmo + 2, 1'b0);
        wait_for_results();

        // zero timing registers, start while busy and on the done tick
        in_idling  = 1'b1;
        out_idling = 1'b1;
        set_config(0, 0, 0, 0, 1'b0);
        seq = '{2'b10, 2'b11, 2'b01, 2'b10, 2'b11, 2'b00, 2'b01, 2'b00,
                2'b00, 2'b00, 2'b10, 2'b00, 2'b10, 2'b00, 2'b00};
        foreach (seq[i]) begin
            send_tick(seq[i][0], seq[i][1]);
        end
        wait_for_results();

        for (int p = 1; p < 6; p++) begin
            in_idling  = ($urandom_range(0, 3) != 0);
            out_idling = ($urandom_range(0, 3) != 0);
            n = 1;
            case (p)
                1: begin
                    in_idling  = 1'b0;
                    out_idling = 1'b0;
                    set_config(20, 3, 0, 9, 1'b0);
                end
                2: begin
                    set_config(1, 1, 0, 1, 1'b0);
                end
                3: begin
                    set_config(1, 2, 0, 0, 1'b1);
                end
                default: begin
                    thr = $urandom_range(0, 5);
                    set_config(($urandom_range(0, 5) == 0) ? $urandom_range(9, 300)
                                                           : $urandom_range(0, 8),
                               $urandom_range(0, 6), thr,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(thr + 3, thr + 12),
                               1'b1);
                end
            endcase
            if (p == 4) begin
                in_idling = 1'b0;
                hold_off_req = 1'b1;
            end
            for (int r = 0; r < n; r++) begin
                run_reading(p > 3);
            end
            wait_for_results();
        end

        repeat (4) @(posedge i_clk);
        if (readings.errors == 0) begin
            $display("[single_wire_sensor_receiver] OK");
        end else begin
            $display("[single_wire_sensor_receiver] ERROR");
        end
        $finish;
    end

endmodule
